>>> sv/encoder_position_and_speed_macros.svh
// Assertion macros for the encoder position and speed block.
// Used by the top level only; no other dependencies.
`ifndef ENCODER_POSITION_AND_SPEED_MACROS_SVH
`define ENCODER_POSITION_AND_SPEED_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define EPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder_position_and_speed: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define EPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder_position_and_speed: next-cycle check failed");

`endif

>>> sv/eps_pkg.sv
// Shared widths, codes and constants of the encoder position and speed block.
// No dependencies; imported by every module of the block.
package eps_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int POS_W        = 32;
    localparam int CPR_W        = 20;
    localparam int TIME_W       = 32;

    // Serial multiplier: 32-bit multiplicand, 20-bit multiplier.
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 20;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Serial divider: 48-bit dividend (|dpos| * 60000 < 2^47).
    localparam int NUM_W     = 48;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [MUL_B_W-1:0] MS_PER_MINUTE = MUL_B_W'(60000);

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_RPM    = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DT = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    typedef logic [POS_W-1:0] t_pos;

endpackage

>>> sv/encoder_position_and_speed.sv
// Top level of the encoder position and speed block: command handling, state,
// speed sequencer and output register. Depends on eps_pkg, eps_mul, eps_div.
//
// Usage: each transfer on the slave stream carries one command in tuser and
// the counter sample, timestamp and load value in tdata. Every accepted item
// produces exactly one result transfer on the master stream with the position
// and speed in tdata and the status code in tuser.
// Sample and load commands (and the unused code) pass from S_IDLE to S_DONE
// and then into the output register; a speed command with zero elapsed time
// takes the same path by way of S_PREP. Any other speed command passes S_PREP,
// then two bit-serial multipliers run side by side (|dpos|*60000 and
// counts_per_revolution*dt), then a restoring divider yields one quotient bit
// per cycle, then S_SAT saturates the result and S_DONE hands it to the output
// register. One item is in work at a time. The configuration channel loads
// counts_per_revolution; it is always ready. The user must write it only
// while the block is idle; the block itself does not enforce this. A value
// of zero acts as 1. Reset (synchronous, active low) clears the position,
// the last counter sample, the previous timestamp and the previous speed
// position, and sets counts_per_revolution to 1.
// A finished result sits in the output register while the next item is
// accepted; if the receiver stalls and a further result is ready, the
// sequencer holds it and stops accepting input until the register frees up.
`include "encoder_position_and_speed_macros.svh"

module encoder_position_and_speed import eps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: [19:0] counts_per_revolution.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data,
    // Slave stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] counter_value, [47:16] time_ms, [79:48] new_position.
    input  logic [79:0] i_s_axis_tdata,
    // [1:0] command.
    input  logic [1:0]  i_s_axis_tuser,
    // Master stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] position, [63:32] speed_rpm.
    output logic [63:0] o_m_axis_tdata,
    // [1:0] status.
    output logic [1:0]  o_m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_SAT,
        S_DONE
    } t_state;

    t_state r_state;

    logic [CPR_W-1:0]        r_cpr;
    logic [COUNTER_BITS-1:0] r_last;
    t_pos                    r_pos;
    logic [TIME_W-1:0]       r_prev_time;
    t_pos                    r_prev_spos;
    logic [TIME_W-1:0]       r_dt;
    logic                    r_neg;
    logic [MUL_A_W-1:0]      r_mag;
    logic                    r_mul_start;
    logic                    r_div_start;
    t_pos                    r_speed;
    logic [1:0]              r_status;

    logic        r_m_valid;
    logic [63:0] r_m_data;
    logic [1:0]  r_m_user;

    // Input field views.
    logic [15:0]             w_counter;
    logic [TIME_W-1:0]       w_time;
    t_pos                    w_new_pos;
    logic [1:0]              w_cmd;
    logic [POS_W-1:0]        w_cnt_ext;
    logic [COUNTER_BITS-1:0] w_cur;
    logic [COUNTER_BITS-1:0] w_diff;
    t_pos                    w_sampled_pos;
    logic                    w_accept;
    t_pos                    w_dpos;

    // Views used by the checks at the end.
    logic                    w_load_accept;
    logic                    w_out_sat;
    logic                    w_out_zero_dt;
    t_pos                    w_out_speed;
    logic                    w_out_bound;

    logic              w_num_done;
    logic              w_den_done;
    logic [PROD_W-1:0] w_num_prod;
    logic [PROD_W-1:0] w_den_prod;
    logic              w_div_busy;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quo;

    always_comb begin
        w_counter     = i_s_axis_tdata[15:0];
        w_time        = i_s_axis_tdata[47:16];
        w_new_pos     = i_s_axis_tdata[79:48];
        w_cmd         = i_s_axis_tuser;
        w_cnt_ext     = POS_W'(w_counter);
        w_cur         = w_cnt_ext[COUNTER_BITS-1:0];
        // The wrap-aware difference is the counter delta read as two's complement.
        w_diff        = w_cur - r_last;
        w_sampled_pos = r_pos + POS_W'(signed'(w_diff));
        w_accept      = i_s_axis_tvalid && o_s_axis_tready;
        w_dpos        = r_pos - r_prev_spos;
        w_load_accept = w_accept && (w_cmd == CMD_LOAD);
        w_out_sat     = o_m_axis_tvalid && (o_m_axis_tuser == STATUS_SAT);
        w_out_zero_dt = o_m_axis_tvalid && (o_m_axis_tuser == STATUS_ZERO_DT);
        w_out_speed   = o_m_axis_tdata[63:32];
        w_out_bound   = (w_out_speed == 32'h7FFF_FFFF) || (w_out_speed == 32'h8000_0000);
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;

    // Configuration register; zero is stored as one so the divisor never vanishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr <= CPR_W'(1);
        end else if (i_cfg_valid) begin
            r_cpr <= (i_cfg_data[CPR_W-1:0] == '0) ? CPR_W'(1) : i_cfg_data[CPR_W-1:0];
        end
    end

    // Sequencer, block state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_pos       <= '0;
            r_prev_time <= '0;
            r_prev_spos <= '0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            // In S_DONE the register may drain and refill in the same cycle.
            if (r_m_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_speed  <= '0;
                        r_status <= STATUS_OK;
                        r_state  <= S_DONE;
                        case (w_cmd)
                            CMD_SAMPLE: begin
                                r_last <= w_cur;
                                r_pos  <= w_sampled_pos;
                            end
                            CMD_RPM: begin
                                r_last      <= w_cur;
                                r_pos       <= w_sampled_pos;
                                r_dt        <= w_time - r_prev_time;
                                r_prev_time <= w_time;
                                r_state     <= S_PREP;
                            end
                            CMD_LOAD: begin
                                r_pos <= w_new_pos;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    // Position change since the last speed command, as a sign and magnitude.
                    r_prev_spos <= r_pos;
                    r_neg       <= w_dpos[POS_W-1];
                    r_mag       <= w_dpos[POS_W-1] ? (POS_W'(0) - w_dpos) : w_dpos;
                    if (r_dt == '0) begin
                        r_status <= STATUS_ZERO_DT;
                        r_state  <= S_DONE;
                    end else begin
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_num_done && w_den_done) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (r_neg) begin
                        if (w_quo > NUM_W'(33'h0_8000_0000)) begin
                            r_speed  <= 32'h8000_0000;
                            r_status <= STATUS_SAT;
                        end else begin
                            r_speed <= POS_W'(0) - w_quo[POS_W-1:0];
                        end
                    end else begin
                        if (w_quo > NUM_W'(32'h7FFF_FFFF)) begin
                            r_speed  <= 32'h7FFF_FFFF;
                            r_status <= STATUS_SAT;
                        end else begin
                            r_speed <= w_quo[POS_W-1:0];
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {r_speed, r_pos};
                        r_m_user  <= r_status;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Numerator |dpos| * 60000 and divisor counts_per_revolution * dt in parallel.
    eps_mul u_mul_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mag),
        .i_b     (MS_PER_MINUTE),
        .o_done  (w_num_done),
        .o_prod  (w_num_prod)
    );

    eps_mul u_mul_den (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_dt),
        .i_b     (r_cpr),
        .o_done  (w_den_done),
        .o_prod  (w_den_prod)
    );

    eps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_num_prod[NUM_W-1:0]),
        .i_den   (w_den_prod),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    // A load command sets the position to the loaded value in the next cycle.
    `EPS_ASSERT_NEXT(a_load_pos, i_clk, i_rst_n, w_load_accept, r_pos == $past(w_new_pos))
    // No input is taken while the divider is working.
    `EPS_ASSERT_NOW(a_busy_stall, i_clk, i_rst_n, w_div_busy, !o_s_axis_tready)
    // A saturated result carries one of the two 32-bit bounds.
    `EPS_ASSERT_NOW(a_sat_bound, i_clk, i_rst_n, w_out_sat, w_out_bound)
    // A zero elapsed time always reports a zero speed.
    `EPS_ASSERT_NOW(a_zero_dt, i_clk, i_rst_n, w_out_zero_dt, w_out_speed == 32'h0)

endmodule

>>> sv/eps_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on eps_pkg for its widths.
module eps_mul import eps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [PROD_W-1:0]  o_prod
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_acc;
    logic [PROD_W-1:0]    r_a;
    logic [MUL_B_W-1:0]   r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand whenever the low multiplier bit is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= PROD_W'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[PROD_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> sv/eps_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on eps_pkg for its widths.
module eps_div import eps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [PROD_W-1:0] i_den,
    output logic              o_busy,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_rem;
    logic [PROD_W-1:0]    r_den;
    logic [NUM_W-1:0]     r_quo;

    logic [PROD_W:0]   w_trial;
    logic [PROD_W:0]   w_sub;
    logic              w_ge;
    logic [PROD_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_sub   = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_sub[PROD_W-1:0] : w_trial[PROD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top of r_quo while quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> tb/encoder_position_and_speed_tb.sv
// Self-checking testbench for the encoder position and speed block.
// Depends on eps_pkg and encoder_position_and_speed; drives both streams and the
// configuration channel and checks every result against its own predictor or a directed row.
`timescale 1ns / 100ps

module encoder_position_and_speed_tb;
    import eps_pkg::*;

    // The command code that the block accepts but does not act on.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RESET_CYCLES    = 11;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PHASE_COUNT     = 6;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 100;
    localparam int STALL_LIMIT     = 4000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] speed;
        logic [1:0]       status;
    } t_result;

    // One directed stimulus row; the expectation is used only when known is set.
    typedef struct packed {
        logic [1:0]              cmd;
        logic [COUNTER_BITS-1:0] count;
        logic [TIME_W-1:0]       stamp;
        logic [POS_W-1:0]        load;
        logic                    known;
        logic [POS_W-1:0]        pos;
        logic [POS_W-1:0]        speed;
        logic [1:0]              status;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [79:0] i_s_axis_tdata = '0;  // [15:0] counter, [47:16] time_ms, [79:48] new_position
    logic [1:0]  i_s_axis_tuser = '0;  // [1:0] command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;       // [31:0] position, [63:32] speed_rpm
    logic [1:0]  o_m_axis_tuser;       // [1:0] status

    encoder_position_and_speed dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state, mirroring the block after reset.
    logic [CPR_W-1:0]        rev_counts = CPR_W'(1);
    logic [COUNTER_BITS-1:0] last_count = '0;
    logic [POS_W-1:0]        position = '0;
    logic [TIME_W-1:0]       prev_rpm_time = '0;
    logic [POS_W-1:0]        prev_rpm_position = '0;

    t_result     expected_results [$];
    int          errors = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int unsigned hold_seq = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int          stall_cycles = 0;

    // Sender-side view of the last counter and timestamp, used to build
    // well-formed sequences with small steps.
    logic [COUNTER_BITS-1:0] tx_count = '0;
    logic [TIME_W-1:0]       tx_stamp = '0;

    // Directed rows start from the reset state with one count per revolution.
    t_stim_row directed_rows [24] = '{
        // Plain sample and a zero elapsed time straight after reset.
        '{CMD_SAMPLE, 16'h0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'd0, STATUS_OK},
        '{CMD_RPM,    16'h0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'd0, STATUS_ZERO_DT},
        // Counter wrap in both directions and the half-range step.
        '{CMD_SAMPLE, 16'hFFFF, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'hFFFF_FFFF, 32'd0, STATUS_OK},
        '{CMD_SAMPLE, 16'h0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'd0, STATUS_OK},
        '{CMD_SAMPLE, 16'h7FFF, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_7FFF, 32'd0, STATUS_OK},
        '{CMD_SAMPLE, 16'h8000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_8000, 32'd0, STATUS_OK},
        '{CMD_SAMPLE, 16'h0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'd0, STATUS_OK},
        // Load and position overflow in both directions.
        '{CMD_LOAD,   16'hABCD, 32'h1234_5678, 32'h7FFF_FFFF,
          1'b1, 32'h7FFF_FFFF, 32'd0, STATUS_OK},
        '{CMD_SAMPLE, 16'h0001, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h8000_0000, 32'd0, STATUS_OK},
        '{CMD_LOAD,   16'h5555, 32'hAAAA_AAAA, 32'h8000_0000,
          1'b1, 32'h8000_0000, 32'd0, STATUS_OK},
        '{CMD_SAMPLE, 16'h0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h7FFF_FFFF, 32'd0, STATUS_OK},
        // The unused code only reports the position.
        '{CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000,
          1'b1, 32'h7FFF_FFFF, 32'd0, STATUS_OK},
        // Positive saturation, one exact count, negative saturation.
        '{CMD_RPM,    16'h0000, 32'h0000_0001, 32'h0000_0000,
          1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, STATUS_SAT},
        '{CMD_LOAD,   16'h0000, 32'h0000_0000, 32'h8000_0000,
          1'b1, 32'h8000_0000, 32'd0, STATUS_OK},
        '{CMD_RPM,    16'h0000, 32'h0000_0002, 32'h0000_0000,
          1'b1, 32'h8000_0000, 32'd60000, STATUS_OK},
        '{CMD_LOAD,   16'h0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'd0, STATUS_OK},
        '{CMD_RPM,    16'h0000, 32'h0000_0003, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'h8000_0000, STATUS_SAT},
        // Timestamp wrap, negative speed, truncation toward zero, repeated stamp.
        '{CMD_RPM,    16'h0010, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0, '0, STATUS_OK},
        '{CMD_RPM,    16'h0020, 32'h0000_0009, 32'h0000_0000, 1'b0, '0, '0, STATUS_OK},
        '{CMD_RPM,    16'h0010, 32'h0000_000C, 32'h0000_0000, 1'b0, '0, '0, STATUS_OK},
        '{CMD_RPM,    16'h000F, 32'h0000_0013, 32'h0000_0000, 1'b0, '0, '0, STATUS_OK},
        '{CMD_RPM,    16'h000F, 32'h0000_0013, 32'h0000_0000, 1'b0, '0, '0, STATUS_OK},
        '{CMD_RPM,    16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, '0, STATUS_OK},
        '{CMD_SAMPLE, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, '0, STATUS_OK}
    };

    // Advances the predictor by one command and returns the result it causes.
    function automatic t_result predict_result(input t_stim_row r);
        t_result                 res;
        logic [COUNTER_BITS-1:0] step;
        logic [TIME_W-1:0]       elapsed;
        logic [POS_W-1:0]        travel;
        logic [POS_W-1:0]        travel_neg;
        logic [63:0]             magnitude;
        logic [63:0]             divisor;
        logic [63:0]             quotient;
        res.speed  = '0;
        res.status = STATUS_OK;
        if (r.cmd == CMD_SAMPLE || r.cmd == CMD_RPM) begin
            step       = r.count - last_count;
            last_count = r.count;
            position   = position + {{(POS_W-COUNTER_BITS){step[COUNTER_BITS-1]}}, step};
        end
        if (r.cmd == CMD_RPM) begin
            elapsed           = r.stamp - prev_rpm_time;
            travel            = position - prev_rpm_position;
            prev_rpm_time     = r.stamp;
            prev_rpm_position = position;
            if (elapsed == '0) begin
                res.status = STATUS_ZERO_DT;
            end else begin
                travel_neg = '0 - travel;
                magnitude  = {32'd0, travel[POS_W-1] ? travel_neg : travel};
                divisor    = {44'd0, (rev_counts == '0) ? CPR_W'(1) : rev_counts}
                           * {32'd0, elapsed};
                quotient   = (magnitude * 64'(MS_PER_MINUTE)) / divisor;
                if (travel[POS_W-1]) begin
                    if (quotient > 64'h8000_0000) begin
                        quotient   = 64'h8000_0000;
                        res.status = STATUS_SAT;
                    end
                    res.speed = '0 - quotient[POS_W-1:0];
                end else begin
                    if (quotient > 64'h7FFF_FFFF) begin
                        quotient   = 64'h7FFF_FFFF;
                        res.status = STATUS_SAT;
                    end
                    res.speed = quotient[POS_W-1:0];
                end
            end
        end
        if (r.cmd == CMD_LOAD) begin
            position = r.load;
        end
        res.pos = position;
        return res;
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Offers one item after a random gap and records its expectation once the
    // transfer has taken place.
    task automatic send_item(input t_stim_row r);
        int      gap;
        t_result want;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r.load, r.stamp, r.count};
        i_s_axis_tuser  <= r.cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        want = predict_result(r);
        if (r.known) begin
            want.pos    = r.pos;
            want.speed  = r.speed;
            want.status = r.status;
        end
        expected_results.push_back(want);
    endtask

    // Mostly well-formed runs of samples with small counter steps and advancing
    // timestamps; the rest are loads, unused codes and arbitrary jumps.
    task automatic send_random_items(input int count);
        t_stim_row r;
        int        k;
        int        roll;
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 42)      r.cmd = CMD_RPM;
            else if (roll < 80) r.cmd = CMD_SAMPLE;
            else if (roll < 94) r.cmd = CMD_LOAD;
            else                r.cmd = CMD_UNUSED;

            roll = $urandom_range(0, 9);
            if (roll == 0)      r.count = COUNTER_BITS'($urandom);
            else if (roll == 1) r.count = tx_count + COUNTER_BITS'($urandom_range(0, 30000))
                                        - COUNTER_BITS'(15000);
            else                r.count = tx_count + COUNTER_BITS'($urandom_range(0, 4000))
                                        - COUNTER_BITS'(2000);

            roll = $urandom_range(0, 19);
            if (roll == 0)      r.stamp = $urandom;
            else if (roll == 1) r.stamp = tx_stamp;
            else                r.stamp = tx_stamp + TIME_W'($urandom_range(1, 200));

            roll = $urandom_range(0, 9);
            if (roll == 0)      r.load = 32'h7FFF_FFFF;
            else if (roll == 1) r.load = 32'h8000_0000;
            else                r.load = $urandom;

            r.known  = 1'b0;
            r.pos    = '0;
            r.speed  = '0;
            r.status = STATUS_OK;
            if (r.cmd == CMD_SAMPLE || r.cmd == CMD_RPM) tx_count = r.count;
            if (r.cmd == CMD_RPM) tx_stamp = r.stamp;
            send_item(r);
        end
    endtask

    // Every item yields one result, so the block is idle once all are back.
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_rev_counts(input logic [CPR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= {4'd0, value};
        do @(posedge i_clk); while (!o_cfg_ready);
        rev_counts = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: checks each result transfer and drives tready, with an
    // occasional long hold-off that lets the block back up into its input.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.pos    = o_m_axis_tdata[31:0];
                got.speed  = o_m_axis_tdata[63:32];
                got.status = o_m_axis_tuser;
                if (expected_results.size() == 0) begin
                    log_mismatch("unexpected result position", '0, got.pos);
                end else begin
                    want = expected_results.pop_front();
                    if (got.pos !== want.pos) log_mismatch("position", want.pos, got.pos);
                    if (got.speed !== want.speed) log_mismatch("speed", want.speed, got.speed);
                    if (got.status !== want.status) begin
                        log_mismatch("status", 32'(want.status), 32'(got.status));
                    end
                end
            end
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [CPR_W-1:0] phase_cpr [PHASE_COUNT];
        int               phase;
        phase_cpr[0] = CPR_W'(1048575);
        phase_cpr[1] = CPR_W'(0);
        phase_cpr[2] = CPR_W'(1);
        phase_cpr[3] = CPR_W'(7);
        phase_cpr[4] = CPR_W'($urandom_range(1, 1048575));
        phase_cpr[5] = CPR_W'(1024);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 21;
        rx_idle_pct = 70;
        foreach (directed_rows[i]) send_item(directed_rows[i]);
        wait_for_results();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 2) begin
                tx_idle_pct = 70;
                rx_idle_pct = 21;
            end
            if (phase == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_rev_counts(phase_cpr[phase]);
            // The sender keeps offering while the receiver is held off.
            if (phase == 4) hold_seq++;
            send_random_items(ITEMS_PER_PHASE);
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
